// ----- src/sha5_pkg.sv -----
// package with types and constants for the sha-512/384 stream hasher
`timescale 1ns / 1ps
package sha5_pkg;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_WAIT,
    P_PAD,
    P_WAIT2,
    P_OUT
  } ph_t;

  typedef struct packed {
    logic       start;
    logic       restart;
    logic       mode;
  } core_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic       done;
  } core_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd1024;

  function automatic logic [63:0] round_k(input logic [6:0] i);
    logic [63:0] k;
    case (i)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] init_word(input logic mode, input logic [2:0] i);
    logic [63:0] w;
    case ({mode, i})
      4'd0: w = 64'h6a09e667f3bcc908; 4'd1: w = 64'hbb67ae8584caa73b;
      4'd2: w = 64'h3c6ef372fe94f82b; 4'd3: w = 64'ha54ff53a5f1d36f1;
      4'd4: w = 64'h510e527fade682d1; 4'd5: w = 64'h9b05688c2b3e6c1f;
      4'd6: w = 64'h1f83d9abfb41bd6b; 4'd7: w = 64'h5be0cd19137e2179;
      4'd8: w = 64'hcbbb9d5dc1059ed8; 4'd9: w = 64'h629a292a367cd507;
      4'd10: w = 64'h9159015a3070dd17; 4'd11: w = 64'h152fecd8f70e5939;
      4'd12: w = 64'h67332667ffc00b31; 4'd13: w = 64'h8eb44a8768581511;
      4'd14: w = 64'hdb0c2e0d64f98fa7; default: w = 64'h47b5481dbefa4fa4;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- src/sha5_if.sv -----
// valid/ready stream interfaces for input bytes and digest words
`timescale 1ns / 1ps
interface sha5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       is_last;
  modport source (output valid, data_byte, byte_valid, is_last, input ready);
  modport sink (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface sha5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- src/sha5_core.sv -----
// compression engine: message schedule memory, chain memory, one round per cycle
`timescale 1ns / 1ps
module sha5_core (
  input  logic                  clk,
  input  logic                  rst,
  input  sha5_pkg::core_ctrl_t  ctrl,
  // block words are written by the controller
  input  logic                  wr_en,
  input  logic [3:0]            wr_addr,
  input  logic [63:0]           wr_data,
  // chain word read port for digest output
  input  logic [2:0]            rd_addr,
  output logic [63:0]           rd_data,
  output sha5_pkg::core_stat_t  stat
);

  logic [63:0] wmem [16];
  logic [63:0] chain [8];
  sha5_pkg::state_t state, state_next;
  logic [6:0]  rnd;
  logic [3:0]  ld;
  logic [63:0] a, b, c, d, e, f, g, h;
  logic [63:0] w_cur, w_new;
  logic [63:0] wm2, wm7, wm15, wm16;
  logic [63:0] t1, t2, s0, s1;
  logic [3:0]  rx;

  // schedule lives in a 16-entry ring, the registers hold the taps
  logic [63:0] tap [16];

  always_comb begin
    state_next = state;
    unique case (state)
      sha5_pkg::ST_FILL:   if (ctrl.start) state_next = sha5_pkg::ST_LOAD;
      sha5_pkg::ST_LOAD:   if (ld == 4'd15) state_next = sha5_pkg::ST_ROUND;
      sha5_pkg::ST_ROUND:  if (rnd == 7'd79) state_next = sha5_pkg::ST_FINISH;
      sha5_pkg::ST_FINISH: if (ld == 4'd7) state_next = sha5_pkg::ST_FILL;
      default:             state_next = sha5_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    stat.busy = (state != sha5_pkg::ST_FILL);
    stat.done = (state == sha5_pkg::ST_FINISH) && (ld == 4'd7);
  end

  assign wm2  = tap[14];
  assign wm7  = tap[9];
  assign wm15 = tap[1];
  assign wm16 = tap[0];
  assign s0 = sha5_pkg::rotr(wm15, 1) ^ sha5_pkg::rotr(wm15, 8) ^ (wm15 >> 7);
  assign s1 = sha5_pkg::rotr(wm2, 19) ^ sha5_pkg::rotr(wm2, 61) ^ (wm2 >> 6);
  assign w_new = wm16 + s0 + wm7 + s1;
  assign w_cur = (rnd < 7'd16) ? tap[0] : w_new;
  assign t1 = h + (sha5_pkg::rotr(e, 14) ^ sha5_pkg::rotr(e, 18) ^ sha5_pkg::rotr(e, 41))
            + ((e & f) ^ (~e & g)) + sha5_pkg::round_k(rnd) + w_cur;
  assign t2 = (sha5_pkg::rotr(a, 28) ^ sha5_pkg::rotr(a, 34) ^ sha5_pkg::rotr(a, 39))
            + ((a & b) ^ (a & c) ^ (b & c));
  assign rx = ld;

  always_ff @(posedge clk) begin
    if (wr_en) wmem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= chain[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha5_pkg::ST_FILL;
      rnd <= '0;
      ld <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha5_pkg::init_word(1'b0, 3'(i));
    end else begin
      state <= state_next;
      if (ctrl.restart) begin
        for (int i = 0; i < 8; i++) chain[i] <= sha5_pkg::init_word(ctrl.mode, 3'(i));
      end
      unique case (state)
        sha5_pkg::ST_FILL: begin
          ld <= '0;
          rnd <= '0;
        end
        sha5_pkg::ST_LOAD: begin
          for (int i = 0; i < 15; i++) tap[i] <= tap[i+1];
          tap[15] <= wmem[rx];
          ld <= ld + 4'd1;
          a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
          e <= chain[4]; f <= chain[5]; g <= chain[6]; h <= chain[7];
        end
        sha5_pkg::ST_ROUND: begin
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          for (int i = 0; i < 15; i++) tap[i] <= tap[i+1];
          tap[15] <= w_cur;
          rnd <= rnd + 7'd1;
          ld <= '0;
        end
        sha5_pkg::ST_FINISH: begin
          // one chain word per cycle, rotated through the working registers
          chain[ld[2:0]] <= chain[ld[2:0]] + a;
          a <= b; b <= c; c <= d; d <= e; e <= f; f <= g; g <= h;
          ld <= ld + 4'd1;
        end
        default: ;
      endcase
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> state == sha5_pkg::ST_FILL)
    else $error("core did not return to idle");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    state == sha5_pkg::ST_ROUND |-> rnd < 7'd80)
    else $error("round counter out of range");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> state == sha5_pkg::ST_FILL)
    else $error("start while busy");

endmodule

// ----- src/sha512_sha384_stream_hasher_unit.sv -----
// top level: byte packing, padding, length count and digest output
// Bytes are packed into 64-bit words in a 16-word block memory inside the core;
// a byte is taken each cycle while the buffer fills. The cycle that takes the
// 128th byte starts the compression, which then holds the input off through 16
// word loads, 80 rounds on one shared round unit and 8 chain adds. A last item
// is followed by a wait until the core is idle (through the rest of any
// compression that its byte started), a pass of pad word writes over the 16
// block addresses and a compression; when fewer than 16 bytes are left for the
// length, the writes and the compression run twice. Each digest word is first
// read from the chain memory into a register before it is offered and is held
// until its transfer, so words never leave back to back. No input is taken from
// the last item until the final digest word has been transferred.
`timescale 1ns / 1ps
module sha512_sha384_stream_hasher_unit (
  input  logic  clk,
  input  logic  rst,
  input  logic  digest_mode_we,
  input  logic  digest_mode_wdata,
  sha5_in_if.sink    in_s,
  sha5_out_if.source out_s
);

  sha5_pkg::ph_t ph, ph_next;
  logic        mode;
  logic [6:0]  fill;
  logic [63:0] len_lo, len_hi;
  logic [63:0] acc;
  logic        pend_last;
  logic        second;
  logic [3:0]  padw;
  logic [2:0]  oidx;
  logic        ovalid;
  logic        rd_pend;
  sha5_pkg::core_ctrl_t ctrl;
  sha5_pkg::core_stat_t stat;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [63:0] wr_data;
  logic [2:0]  rd_addr;
  logic [63:0] rd_data;
  logic        take;
  logic [63:0] word_b;
  logic [63:0] lo_add;
  logic [2:0]  words_m1;
  logic [63:0] padword;
  logic [3:0]  fw;

  assign in_s.ready = (ph == sha5_pkg::P_IDLE) && !stat.busy;
  assign take = in_s.valid && in_s.ready;
  assign word_b = {acc[55:0], in_s.data_byte};
  assign words_m1 = mode ? 3'd5 : 3'd7;
  assign fw = fill[6:3];

  // pad word at address padw, given final fill count
  always_comb begin
    padword = '0;
    if (padw == 4'd14 && !second) padword = len_hi;
    else if (padw == 4'd15 && !second) padword = len_lo;
    else if (padw == fw && !pend_last) begin
      for (int i = 0; i < 8; i++) begin
        if (i < fill[2:0]) padword[63-8*i -: 8] = acc[8*(fill[2:0]-1-i) +: 8];
        else if (i == fill[2:0]) padword[63-8*i -: 8] = sha5_pkg::PAD_BYTE;
      end
    end
  end

  // words below the fill point still hold message bytes on the first pass
  always_comb begin
    wr_en = 1'b0;
    wr_addr = fw;
    wr_data = word_b;
    if (take && in_s.byte_valid && fill[2:0] == 3'd7) wr_en = 1'b1;
    if (ph == sha5_pkg::P_PAD && (padw >= fw || pend_last)) begin
      wr_en = 1'b1;
      wr_addr = padw;
      wr_data = padword;
    end
  end

  assign lo_add = len_lo + {54'd0, fill, 3'd0};
  assign rd_addr = oidx;

  always_comb begin
    ctrl.mode = digest_mode_wdata;
    ctrl.restart = digest_mode_we ||
                   (ovalid && out_s.ready && oidx == words_m1);
    if (!digest_mode_we) ctrl.mode = mode;
    ctrl.start = 1'b0;
    if (take && in_s.byte_valid && fill == 7'd127) ctrl.start = 1'b1;
    if (ph == sha5_pkg::P_PAD && padw == 4'd15) ctrl.start = 1'b1;
  end

  always_comb begin
    ph_next = ph;
    unique case (ph)
      sha5_pkg::P_IDLE:  if (take && in_s.is_last) ph_next = sha5_pkg::P_WAIT;
      sha5_pkg::P_WAIT:  if (!stat.busy) ph_next = sha5_pkg::P_PAD;
      sha5_pkg::P_PAD:   if (padw == 4'd15) ph_next = sha5_pkg::P_WAIT2;
      sha5_pkg::P_WAIT2: if (stat.done) begin
        ph_next = second ? sha5_pkg::P_PAD : sha5_pkg::P_OUT;
      end
      sha5_pkg::P_OUT:   if (ovalid && out_s.ready && oidx == words_m1) begin
        ph_next = sha5_pkg::P_IDLE;
      end
      default:           ph_next = sha5_pkg::P_IDLE;
    endcase
  end

  assign out_s.valid = ovalid;
  assign out_s.digest_word = rd_data;
  assign out_s.word_index = oidx;
  assign out_s.last_word = (oidx == words_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= sha5_pkg::P_IDLE; mode <= 1'b0; fill <= '0; len_lo <= '0; len_hi <= '0;
      pend_last <= 1'b0; second <= 1'b0; padw <= '0; oidx <= '0;
      ovalid <= 1'b0; rd_pend <= 1'b0;
    end else if (digest_mode_we) begin
      mode <= digest_mode_wdata; fill <= '0; len_lo <= '0; len_hi <= '0;
      ph <= sha5_pkg::P_IDLE; ovalid <= 1'b0; rd_pend <= 1'b0; oidx <= '0;
      pend_last <= 1'b0; second <= 1'b0;
    end else begin
      ph <= ph_next;
      case (ph)
        sha5_pkg::P_IDLE: if (take && in_s.byte_valid) begin
          acc <= word_b;
          fill <= fill + 7'd1;
          if (fill == 7'd127) begin
            {len_hi, len_lo} <= {len_hi, len_lo} + {64'd0, sha5_pkg::BLOCK_BITS};
          end
        end
        sha5_pkg::P_WAIT: if (!stat.busy) begin
          // fill now final; add bits, decide on an extra block
          if (lo_add < len_lo) len_hi <= len_hi + 64'd1;
          len_lo <= lo_add;
          second <= (fill > 7'd111);
          padw <= '0;
        end
        sha5_pkg::P_PAD: padw <= padw + 4'd1;
        sha5_pkg::P_WAIT2: if (stat.done) begin
          if (second) begin
            second <= 1'b0; pend_last <= 1'b1;
          end else begin
            oidx <= '0; rd_pend <= 1'b1;
          end
        end
        sha5_pkg::P_OUT: begin
          rd_pend <= ovalid && out_s.ready && oidx != words_m1;
          if (rd_pend) ovalid <= 1'b1;
          else if (ovalid && out_s.ready) begin
            ovalid <= 1'b0;
            if (oidx == words_m1) begin
              fill <= '0; len_lo <= '0; len_hi <= '0;
              pend_last <= 1'b0; oidx <= '0;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  sha5_core u_core (
    .clk(clk), .rst(rst), .ctrl(ctrl),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data), .stat(stat)
  );

  a_no_out_while_in: assert property (@(posedge clk) disable iff (rst)
    out_s.valid |-> !in_s.ready)
    else $error("input open during digest output");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_s.valid && out_s.last_word |-> out_s.word_index == words_m1)
    else $error("last word at wrong index");
  a_pad_idle_core: assert property (@(posedge clk) disable iff (rst)
    ph == sha5_pkg::P_PAD |-> !stat.busy)
    else $error("pad written while core busy");

endmodule

// ----- verif/sha5_tb_if.sv -----
// the interfaces are declared in src/sha5_if.sv; this file holds the digest record type
`timescale 1ns / 1ps
package sha5_tb_pkg;
  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_rec_t;
endpackage

// ----- verif/sha5_checker.sv -----
// checker: predicts digest words from the accepted byte stream and compares them
`timescale 1ns / 1ps
module sha5_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       mode_we,
  input  logic       mode_wdata,
  sha5_in_if         in_m,
  sha5_out_if        out_m,
  output int         fail_count,
  output int         pending,
  output int         digests_seen
);

  localparam logic [63:0] K_TAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  localparam logic [63:0] IV_TAB [2][8] = '{
    '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179},
    '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4}};

  logic [63:0]  hash_h [8];
  logic [7:0]   blk [128];
  int unsigned  fill;
  logic [127:0] bit_len;
  logic         mode;
  sha5_tb_pkg::digest_rec_t digest_q [$];

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, e, a;
    for (int i = 0; i < 16; i++)
      for (int b = 0; b < 8; b++) w[i] = {w[i][55:0], blk[i*8+b]};
    for (int i = 16; i < 80; i++)
      w[i] = w[i-16] + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-7]
             + (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6));
    v = hash_h;
    for (int i = 0; i < 80; i++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & v[5]) ^ (~e & v[6]))
           + K_TAB[i] + w[i];
      t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  task automatic restart_hash();
    hash_h = IV_TAB[mode];
    fill = 0;
    bit_len = '0;
  endtask

  task automatic absorb_item(input logic [7:0] d, input logic bv, input logic lst);
    int unsigned f;
    int unsigned nw;
    sha5_tb_pkg::digest_rec_t r;
    if (bv) begin
      blk[fill] = d;
      fill++;
      if (fill == 128) begin
        compress();
        bit_len = bit_len + 128'd1024;
        fill = 0;
      end
    end
    if (lst) begin
      f = fill;
      bit_len = bit_len + 128'(f * 8);
      blk[f] = 8'h80;
      f++;
      if (f > 112) begin
        for (int i = f; i < 128; i++) blk[i] = 8'h00;
        compress();
        f = 0;
      end
      for (int i = f; i < 112; i++) blk[i] = 8'h00;
      for (int i = 0; i < 16; i++) blk[112+i] = bit_len[127-8*i -: 8];
      compress();
      nw = mode ? 6 : 8;
      for (int i = 0; i < nw; i++) begin
        r.digest_word = hash_h[i];
        r.word_index = 3'(i);
        r.last_word = (i + 1 == nw);
        digest_q.push_back(r);
      end
      restart_hash();
    end
  endtask

  always @(posedge clk) begin
    sha5_tb_pkg::digest_rec_t exp_r;
    if (rst) begin
      mode = 1'b0;
      restart_hash();
      digest_q.delete();
      fail_count = 0;
      digests_seen = 0;
    end else begin
      if (mode_we) begin
        mode = mode_wdata;
        restart_hash();
      end
      if (in_m.valid && in_m.ready)
        absorb_item(in_m.data_byte, in_m.byte_valid, in_m.is_last);
      if (out_m.valid && out_m.ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h idx %0d", out_m.digest_word, out_m.word_index);
        end else begin
          exp_r = digest_q.pop_front();
          if (exp_r.last_word) digests_seen++;
          if (exp_r.digest_word !== out_m.digest_word || exp_r.word_index !== out_m.word_index
              || exp_r.last_word !== out_m.last_word) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_r.digest_word,
                       exp_r.word_index, exp_r.last_word, out_m.digest_word,
                       out_m.word_index, out_m.last_word);
          end
        end
      end
    end
    pending = digest_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// testbench top: byte stream stimulus, mode writes and pass/fail verdict
`timescale 1ns / 1ps
module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic mode_we = 1'b0;
  logic mode_wdata = 1'b0;
  int   fail_count;
  int   pending;
  int   digests_seen;
  int   items_sent = 0;
  logic hold_rx = 1'b0;

  sha5_in_if  in_c ();
  sha5_out_if out_c ();

  sha512_sha384_stream_hasher_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .digest_mode_we    (mode_we),
    .digest_mode_wdata (mode_wdata),
    .in_s              (in_c.sink),
    .out_s             (out_c.source)
  );

  sha5_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .mode_we      (mode_we),
    .mode_wdata   (mode_wdata),
    .in_m         (in_c),
    .out_m        (out_c),
    .fail_count   (fail_count),
    .pending      (pending),
    .digests_seen (digests_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    out_c.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_rx) begin
        out_c.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_c.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_c.ready <= 1'b1;
      @(posedge clk);
      while (!out_c.valid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [7:0] d, input logic bv, input logic lst,
                           input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_c.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_c.valid <= 1'b1;
    in_c.data_byte <= d;
    in_c.byte_valid <= bv;
    in_c.is_last <= lst;
    @(posedge clk);
    while (!in_c.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_c.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    mode_we <= 1'b1;
    mode_wdata <= m;
    @(posedge clk);
    mode_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_msg(input int len, input int kind, input bit gaps);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      d = (kind == 0) ? 8'h00 : (kind == 1) ? 8'hff : 8'($urandom);
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, gaps);
      send_item(d, 1'b1, 1'b0, gaps);
    end
    if ($urandom_range(0, 1)) send_item(8'($urandom), 1'b0, 1'b1, gaps);
    else if (len > 0) send_item(8'($urandom), 1'b1, 1'b1, gaps);
    else send_item(8'h00, 1'b0, 1'b1, gaps);
  endtask

  initial begin
    int len;
    in_c.valid = 1'b0;
    in_c.data_byte = 8'h00;
    in_c.byte_valid = 1'b0;
    in_c.is_last = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, one-byte closing items, in both modes
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b1);
    drain();
    write_mode(1'b1);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1, 1'b0);
    drain();
    // abandon a message in progress with a mode write
    send_item(8'h12, 1'b1, 1'b0, 1'b0);
    drain();
    write_mode(1'b0);
    send_item(8'h34, 1'b1, 1'b1, 1'b0);
    drain();

    // random messages across pad boundaries and both modes
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      for (int m = 0; m < 3; m++) begin
        case (m)
          0: begin
            if (ph == 1) len = $urandom_range(126, 130);
            else if (ph == 2) len = $urandom_range(1, 16);
            else len = $urandom_range(110, 113);
          end
          1: len = $urandom_range(0, 3);
          default: len = $urandom_range(1, 24);
        endcase
        if (ph == 1 && m == 0) hold_rx = 1'b1;
        send_msg(len, (m == 0) ? 0 : (m == 1) ? 1 : 2, ph != 2);
        // pause until every digest word is back
        if (ph == 2 && m == 1) drain();
      end
      drain();
    end

    $display("covered %0d input items, %0d digests, sha-512 and sha-384 modes",
             items_sent, digests_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
